FILE: hw/rtl/rsi_pkg.sv
package rsi_pkg;

   // fixed field widths
   localparam int COORD_W    = 32;
   localparam int RSQ_W      = 48;
   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   // limb width of the split multipliers
   localparam int MUL_LIMB_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_SQUARED = 2'd3;

   localparam logic [RSQ_W-1:0] RSQ_RESET = 48'd65536;

   // face codes
   localparam logic FACE_FRONT = 1'b0;
   localparam logic FACE_BACK  = 1'b1;

   // flags that ride along the divider
   typedef struct packed {
      logic hit;
      logic enclosed;
      logic neg;
      logic ovf;
   } div_flags_type;

endpackage

FILE: hw/rtl/ray_sphere_intersect.sv
// Ray against sphere test. Each beat on req carries one ray (origin and direction, signed
// fixed point with COORD_FRAC_BITS fraction bits); each produces exactly one beat on rsp with
// hit, the near-root distance (saturated to 32 bits), entry/exit face codes and a saturation
// flag. The sphere center and squared radius come from the csr write port (index 0..2 center
// x/y/z, 3 radius squared) and must only be written while no ray is in flight. All products
// are exact, the square root is the floor root and the distance is the floor quotient.
// Tangent rays and zero directions report a miss with all other fields zero. One ray is
// accepted every cycle while the pipe advances. Most of the depth lies in the two bit-per-stage
// units, the square root of 68 stages at the default fraction width and the 33-step divider.
// The whole pipe advances together: it moves whenever the output register is empty or being
// taken.
module ray_sphere_intersect
   import rsi_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each, low first)
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response: distance[31:0], entry_face[32], exit_face[33], saturated[34], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // response user: hit
   output logic                  rsp_tuser,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int F    = COORD_FRAC_BITS;
   localparam int CW   = COORD_W;
   localparam int OCW  = CW + 1;                      // origin minus center
   localparam int BW   = OCW + CW + 2;                // b, signed
   localparam int AW   = 2 * CW + 2;                  // a, unsigned
   localparam int LW   = 2 * OCW + 2;                 // |o-c|^2, unsigned
   localparam int R2W  = RSQ_W + F;                   // radius squared at 2F fraction bits
   localparam int TW   = ((LW > R2W) ? LW : R2W) + 1; // len2 - r2, signed
   localparam int BBW  = 2 * BW;
   localparam int ATW  = AW + TW;
   localparam int DW   = ((BBW > ATW) ? BBW : ATW) + 1; // discriminant, signed
   localparam int SQW  = DW / 2;                      // root width
   localparam int NW   = ((BW > SQW + 1) ? BW : SQW + 1) + 1; // -b - s, signed
   localparam int MW   = NW + F;                      // scaled numerator magnitude
   localparam int QB   = CW + 1;                      // quotient bits kept
   localparam int HW   = MW - QB;                     // numerator bits above the quotient
   localparam int CMPW = (HW > AW) ? HW : AW;
   localparam int S5W  = 2 + BW + AW;                 // hit, enclosed, b, a

   localparam logic [CW-1:0] DIST_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] DIST_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [QB:0]   NEG_LIM  = (QB+1)'(1) << (CW - 1);

   logic en;

   // configuration
   logic signed [CW-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [RSQ_W-1:0]     radius_sq_ff;
   logic [R2W-1:0]       r2;

   // stage 1: offsets
   logic signed [CW-1:0]  org [3];
   logic signed [CW-1:0]  dir [3];
   logic signed [CW-1:0]  cen [3];
   logic signed [OCW-1:0] oc_ff [3];
   logic signed [CW-1:0]  d_ff  [3];
   logic                  v1_ff;

   // stage 2: products
   logic signed [OCW+CW-1:0] bp_ff [3];
   logic [2*CW-1:0]          ap_ff [3];
   logic [2*OCW-1:0]         lp_ff [3];
   logic                     v2_ff;

   // stage 3: dot products
   logic signed [BW-1:0] b_in, b_ff;
   logic [AW-1:0]        a_in, a_ff;
   logic [LW-1:0]        l_in, l_ff;
   logic                 v3_ff;

   // stage 4: operands of the wide products
   logic signed [TW-1:0] t_in;
   logic [BW-1:0]        bmag_ff;
   logic [TW-1:0]        tmag_ff;
   logic signed [BW-1:0] b4_ff;
   logic [AW-1:0]        a4_ff;
   logic                 in4_ff;
   logic                 v4_ff;

   // wide products
   logic                 bb_valid;
   logic [BBW-1:0]       bb;
   logic [ATW-1:0]       at;
   logic [S5W-2:0]       mul_side;

   // stage 5: discriminant
   logic [DW-1:0]        disc;
   logic                 hit5;
   logic [2*SQW-1:0]     x5_ff;
   logic [S5W-1:0]       side5_ff;
   logic                 v5_ff;

   // square root
   logic                 sq_valid;
   logic [SQW-1:0]       root;
   logic [S5W-1:0]       sq_side;

   // stage 6: numerator
   logic signed [BW-1:0] b6;
   logic signed [NW-1:0] num;
   logic [NW-1:0]        num_mag;
   logic [MW-1:0]        mag6_ff;
   logic [AW-1:0]        a6_ff;
   div_flags_type        fl6_ff;
   logic                 v6_ff;

   // stage 7: overflow check and divider start
   logic [HW-1:0]        mhi;
   logic [AW-1:0]        rem7_ff;
   logic [QB-1:0]        low7_ff;
   logic [AW-1:0]        a7_ff;
   div_flags_type        fl7_ff;
   logic                 v7_ff;

   // divider stages
   logic [AW-1:0]        drem_ff [QB];
   logic [QB-1:0]        dq_ff   [QB];
   logic [QB-1:0]        dlow_ff [QB];
   logic [AW-1:0]        da_ff   [QB];
   div_flags_type        dfl_ff  [QB];
   logic [QB-1:0]        dv_ff;

   // final
   logic [QB-1:0]        qf;
   logic                 rnz;
   div_flags_type        flf;
   logic [QB:0]          ceilq;
   logic                 sat_in;
   logic [CW-1:0]        dist_in;
   logic                 positive;
   logic                 entry_in, exit_in;

   // output register
   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic [CW-1:0]        dist_ff;
   logic                 entry_ff, exit_ff, sat_ff;

   // whole pipe moves together
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         radius_sq_ff <= RSQ_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X:       center_x_ff  <= csr_data[CW-1:0];
            REG_CENTER_Y:       center_y_ff  <= csr_data[CW-1:0];
            REG_CENTER_Z:       center_z_ff  <= csr_data[CW-1:0];
            REG_RADIUS_SQUARED: radius_sq_ff <= csr_data[RSQ_W-1:0];
            default:            ;
         endcase
      end
   end

   assign r2 = {radius_sq_ff, {F{1'b0}}};

   assign cen[0] = center_x_ff;
   assign cen[1] = center_y_ff;
   assign cen[2] = center_z_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         org[i] = req_tdata[i*CW +: CW];
         dir[i] = req_tdata[(3+i)*CW +: CW];
      end
   end

   // stages 1 to 4
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            oc_ff[i] <= OCW'(org[i]) - OCW'(cen[i]);
            d_ff[i]  <= dir[i];
            bp_ff[i] <= oc_ff[i] * d_ff[i];
            ap_ff[i] <= d_ff[i] * d_ff[i];
            lp_ff[i] <= oc_ff[i] * oc_ff[i];
         end
         b_ff    <= b_in;
         a_ff    <= a_in;
         l_ff    <= l_in;
         bmag_ff <= b_ff[BW-1] ? BW'(-b_ff) : BW'(b_ff);
         tmag_ff <= t_in[TW-1] ? TW'(-t_in) : TW'(t_in);
         b4_ff   <= b_ff;
         a4_ff   <= a_ff;
         in4_ff  <= t_in[TW-1];
      end
   end

   always_comb begin
      b_in = BW'(bp_ff[0]) + BW'(bp_ff[1]) + BW'(bp_ff[2]);
      a_in = AW'(ap_ff[0]) + AW'(ap_ff[1]) + AW'(ap_ff[2]);
      l_in = LW'(lp_ff[0]) + LW'(lp_ff[1]) + LW'(lp_ff[2]);
      // negative means the origin is strictly inside
      t_in = TW'(l_ff) - TW'(r2);
   end

   // b squared, with the enclosed flag, b and a riding along
   rsi_mul #(
      .A_W    (BW),
      .B_W    (BW),
      .SIDE_W (S5W - 1)
   ) u_mul_bb (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .a         (bmag_ff),
      .b         (bmag_ff),
      .side_in   ({in4_ff, b4_ff, a4_ff}),
      .out_valid (bb_valid),
      .prod      (bb),
      .side_out  (mul_side)
   );

   // a times |len2 - r2|
   rsi_mul #(
      .A_W    (AW),
      .B_W    (TW),
      .SIDE_W (1)
   ) u_mul_at (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .a         (a4_ff),
      .b         (tmag_ff),
      .side_in   (1'b0),
      .out_valid (),
      .prod      (at),
      .side_out  ()
   );

   // stage 5: disc = b^2 - a (len2 - r2); sign of the second factor is the enclosed flag
   always_comb begin
      if (mul_side[S5W-2]) begin
         disc = DW'(bb) + DW'(at);
      end else begin
         disc = DW'(bb) - DW'(at);
      end
      hit5 = !disc[DW-1] && (disc != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x5_ff    <= (2*SQW)'(disc[DW-2:0]);
         side5_ff <= {hit5, mul_side};
      end
   end

   rsi_sqrt #(
      .ROOT_W (SQW),
      .SIDE_W (S5W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .x         (x5_ff),
      .side_in   (side5_ff),
      .out_valid (sq_valid),
      .root      (root),
      .side_out  (sq_side)
   );

   // stage 6: -b - s, scaled to the coordinate format
   always_comb begin
      b6      = $signed(sq_side[AW +: BW]);
      num     = -NW'(b6) - $signed(NW'(root));
      num_mag = num[NW-1] ? NW'(-num) : NW'(num);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag6_ff         <= {num_mag, {F{1'b0}}};
         a6_ff           <= sq_side[AW-1:0];
         fl6_ff.hit      <= sq_side[S5W-1];
         fl6_ff.enclosed <= sq_side[S5W-2];
         fl6_ff.neg      <= num[NW-1];
         fl6_ff.ovf      <= 1'b0;
      end
   end

   // stage 7: quotient too large for QB bits means saturation
   assign mhi = mag6_ff[MW-1:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem7_ff         <= AW'(mhi);
         low7_ff         <= mag6_ff[QB-1:0];
         a7_ff           <= a6_ff;
         fl7_ff.hit      <= fl6_ff.hit;
         fl7_ff.enclosed <= fl6_ff.enclosed;
         fl7_ff.neg      <= fl6_ff.neg;
         fl7_ff.ovf      <= (CMPW'(mhi) >= CMPW'(a6_ff));
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [AW-1:0] rem_prev;
      logic [QB-1:0] q_prev;
      logic [QB-1:0] low_prev;
      logic [AW-1:0] a_prev;
      div_flags_type fl_prev;
      logic          v_prev;
      logic [AW:0]   rem2;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_prev = rem7_ff;
         assign q_prev   = '0;
         assign low_prev = low7_ff;
         assign a_prev   = a7_ff;
         assign fl_prev  = fl7_ff;
         assign v_prev   = v7_ff;
      end else begin : g_next
         assign rem_prev = drem_ff[k-1];
         assign q_prev   = dq_ff[k-1];
         assign low_prev = dlow_ff[k-1];
         assign a_prev   = da_ff[k-1];
         assign fl_prev  = dfl_ff[k-1];
         assign v_prev   = dv_ff[k-1];
      end

      assign rem2 = {rem_prev, low_prev[QB-1]};
      assign ge   = (rem2 >= {1'b0, a_prev});

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k] <= ge ? AW'(rem2 - {1'b0, a_prev}) : AW'(rem2);
            dq_ff[k]   <= {q_prev[QB-2:0], ge};
            dlow_ff[k] <= low_prev << 1;
            da_ff[k]   <= a_prev;
            dfl_ff[k]  <= fl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= v_prev;
         end
      end
   end

   // floor quotient, saturation and faces
   always_comb begin
      qf       = dq_ff[QB-1];
      rnz      = (drem_ff[QB-1] != '0);
      flf      = dfl_ff[QB-1];
      // a negative numerator floors away from zero
      ceilq    = (QB+1)'(qf) + (QB+1)'(rnz);
      if (flf.neg) begin
         sat_in  = flf.ovf || (ceilq > NEG_LIM);
         dist_in = sat_in ? DIST_MIN : CW'(-ceilq[CW-1:0]);
      end else begin
         sat_in  = flf.ovf || qf[QB-1] || qf[QB-2];
         dist_in = sat_in ? DIST_MAX : qf[CW-1:0];
      end
      positive = !flf.neg && (flf.ovf || (qf != '0));
      if (flf.enclosed || !positive) begin
         entry_in = FACE_BACK;
         exit_in  = FACE_FRONT;
      end else begin
         entry_in = FACE_FRONT;
         exit_in  = FACE_BACK;
      end
      // misses report zeros
      if (!flf.hit) begin
         sat_in   = 1'b0;
         dist_in  = '0;
         entry_in = 1'b0;
         exit_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= flf.hit;
         dist_ff  <= dist_in;
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
         sat_ff   <= sat_in;
      end
   end

   // valid bits of the local stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= bb_valid;
         v6_ff        <= sq_valid;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= dv_ff[QB-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = RSP_DATA_W'({sat_ff, exit_ff, entry_ff, dist_ff});

endmodule

FILE: hw/rtl/rsi_mul.sv
module rsi_mul
   import rsi_pkg::*;
#(
   parameter int A_W    = 8,
   parameter int B_W    = 8,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output logic [A_W+B_W-1:0]   prod,
   output logic [SIDE_W-1:0]    side_out
);

   localparam int L   = MUL_LIMB_W;
   localparam int NA  = (A_W + L - 1) / L;
   localparam int NB  = (B_W + L - 1) / L;
   localparam int AP  = NA * L;
   localparam int BP  = NB * L;
   localparam int PW  = A_W + B_W;
   localparam int RW  = L * (NB + 1);

   logic [AP-1:0]     a_pad;
   logic [BP-1:0]     b_pad;
   logic [2*L-1:0]    pp_ff [NA][NB];
   logic [RW-1:0]     row_in [NA];
   logic [RW-1:0]     row_ff [NA];
   logic [PW-1:0]     prod_in;
   logic [PW-1:0]     prod_ff;
   logic [2:0]        v_ff;
   logic [SIDE_W-1:0] side_ff [3];

   assign a_pad = AP'(a);
   assign b_pad = BP'(b);

   // row sums of the limb products
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (L * j));
         end
      end
   end

   // rows to the full product
   always_comb begin
      prod_in = '0;
      for (int i = 0; i < NA; i++) begin
         prod_in = prod_in + (PW'(row_ff[i]) << (L * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= a_pad[i*L +: L] * b_pad[j*L +: L];
            end
            row_ff[i] <= row_in[i];
         end
         prod_ff    <= prod_in;
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   assign out_valid = v_ff[2];
   assign prod      = prod_ff;
   assign side_out  = side_ff[2];

endmodule

FILE: hw/rtl/rsi_sqrt.sv
module rsi_sqrt #(
   parameter int ROOT_W = 8,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   x,
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     root,
   output logic [SIDE_W-1:0]     side_out
);

   // one root bit per stage, restoring digit recurrence
   logic [ROOT_W:0]       rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]     root_ff [ROOT_W];
   logic [2*ROOT_W-1:0]   x_ff    [ROOT_W];
   logic [SIDE_W-1:0]     side_ff [ROOT_W];
   logic [ROOT_W-1:0]     v_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [ROOT_W:0]     rem_prev;
      logic [ROOT_W-1:0]   root_prev;
      logic [2*ROOT_W-1:0] x_prev;
      logic [SIDE_W-1:0]   side_prev;
      logic                v_prev;
      logic [ROOT_W+2:0]   rem2;
      logic [ROOT_W+2:0]   trial;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = x;
         assign side_prev = side_in;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign x_prev    = x_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign v_prev    = v_ff[k-1];
      end

      assign rem2  = {rem_prev, x_prev[2*ROOT_W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = (rem2 >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (ROOT_W+1)'(rem2 - trial) : (ROOT_W+1)'(rem2);
            root_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            x_ff[k]    <= x_prev << 2;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule
